>>> hw/rtl/quadratic_root_solver_top_macros.svh
// assertion macros used by the quadratic root solver top
`ifndef QUADRATIC_ROOT_SOLVER_TOP_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_TOP_MACROS_SVH

`ifndef SYNTH
`define QRS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("qrs check failed");
`define QRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("qrs check failed");
`else
`define QRS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define QRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> hw/rtl/qrs_pkg.sv
// widths, codes and sideband types of the quadratic root solver
`default_nettype none
package qrs_pkg;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int EPS_W     = 31;
    localparam int MAG_W     = DATA_W;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int DISC_W    = PROD_W + 2;
    localparam int SQ_IN_W   = DISC_W + (DISC_W % 2);
    localparam int SQ_STAGES = SQ_IN_W / 2;
    localparam int ROOT_W    = SQ_STAGES;
    localparam int SQ_REM_W  = ROOT_W + 3;
    localparam int NMAG_W    = ROOT_W + 1;
    localparam int NUM_W     = ROOT_W + 2;
    localparam int DVD_W     = NMAG_W + FRAC_BITS;
    localparam int DEN_W     = MAG_W + 1;
    localparam int DV_STAGES = DVD_W;

    localparam logic KIND_REAL    = 1'b0;
    localparam logic KIND_COMPLEX = 1'b1;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] b;
        logic [MAG_W-1:0]         amag;
        logic                     aneg;
    } t_sq_side;
endpackage
`default_nettype wire

>>> hw/rtl/quadratic_root_solver_top.sv
// path of an accepted item: input register, stages 1 to 3, square root, stage 4, dividers, output register
// throughput: one item per cycle when not held, set by the fully pipelined square root and dividers
// the whole pipeline holds while a result waits on the master side
// reset: synchronous active low, clears all valid bits, epsilon returns to 1
`default_nettype none
`include "quadratic_root_solver_top_macros.svh"
module quadratic_root_solver_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [qrs_pkg::EPS_W-1:0]     i_cfg_wdata,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // coef_a [31:0], coef_b [63:32], coef_c [95:64]
    input  wire logic [3*qrs_pkg::DATA_W-1:0]  i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // first_value [31:0], second_value [63:32]
    output logic [2*qrs_pkg::DATA_W-1:0]       o_m_axis_tdata,
    // root_kind [0], overflow [1]
    output logic [1:0]                         o_m_axis_tuser
);
    import qrs_pkg::*;

    localparam logic [DVD_W-1:0] SAT_POS = DVD_W'({1'b0, {(DATA_W-1){1'b1}}});
    localparam logic [DVD_W-1:0] SAT_NEG = DVD_W'({1'b1, {(DATA_W-1){1'b0}}});

    // saturate a quotient magnitude with its sign, overflow flag on top
    function automatic logic [DATA_W:0] sat_q(input logic [DVD_W-1:0] q, input logic neg);
        logic [DATA_W-1:0] v;
        logic              ov;
        begin
            ov = 1'b0;
            if (neg) begin
                if (q > SAT_NEG) begin
                    v  = SAT_NEG[DATA_W-1:0];
                    ov = 1'b1;
                end else begin
                    v = DATA_W'(~q[DATA_W-1:0] + 1'b1);
                end
            end else begin
                if (q > SAT_POS) begin
                    v  = SAT_POS[DATA_W-1:0];
                    ov = 1'b1;
                end else begin
                    v = q[DATA_W-1:0];
                end
            end
            sat_q = {ov, v};
        end
    endfunction

    logic w_ce;
    logic [EPS_W-1:0] r_eps;

    // stage 0: input register
    logic                     r_s0_valid;
    logic signed [DATA_W-1:0] r_s0_a, r_s0_b, r_s0_c;
    // stage 1: magnitudes and epsilon substitution
    logic                     r_s1_valid;
    logic signed [DATA_W-1:0] r_s1_b;
    logic [MAG_W-1:0]         r_s1_amag, r_s1_bmag, r_s1_cmag;
    logic                     r_s1_aneg, r_s1_cneg;
    // stage 2: products
    logic                     r_s2_valid;
    logic [PROD_W-1:0]        r_s2_bb, r_s2_ac;
    logic signed [DATA_W-1:0] r_s2_b;
    logic [MAG_W-1:0]         r_s2_amag;
    logic                     r_s2_aneg, r_s2_sdiff;
    // stage 3: discriminant magnitude
    logic                     r_s3_valid;
    logic [DISC_W-1:0]        r_s3_dmag;
    t_sq_side                 r_s3_side;
    // stage 4: numerators
    logic                     r_s4_valid, r_s4_kind;
    logic [DVD_W-1:0]         r_s4_dvd1, r_s4_dvd2;
    logic [DEN_W-1:0]         r_s4_den;
    logic                     r_s4_neg1, r_s4_neg2;
    // valid and kind alongside the dividers
    logic                     r_dv_valid [DV_STAGES];
    logic                     r_dv_kind  [DV_STAGES];
    // output register
    logic                     r_out_valid, r_out_kind, r_out_ovf;
    logic [DATA_W-1:0]        r_out_first, r_out_second;

    assign w_ce = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_W'(1);
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    // stage 1 logic
    logic [EPS_W-1:0] w_eps_eff;
    logic [MAG_W-1:0] w_amag_raw, n_s1_amag, n_s1_bmag, n_s1_cmag;
    logic             n_s1_aneg;

    always_comb begin
        w_eps_eff  = (r_eps == '0) ? EPS_W'(1) : r_eps;
        w_amag_raw = r_s0_a[DATA_W-1] ? MAG_W'(-r_s0_a) : MAG_W'(r_s0_a);
        n_s1_bmag  = r_s0_b[DATA_W-1] ? MAG_W'(-r_s0_b) : MAG_W'(r_s0_b);
        n_s1_cmag  = r_s0_c[DATA_W-1] ? MAG_W'(-r_s0_c) : MAG_W'(r_s0_c);
        if (w_amag_raw < MAG_W'(w_eps_eff)) begin
            n_s1_amag = MAG_W'(w_eps_eff);
            n_s1_aneg = 1'b0;
        end else begin
            n_s1_amag = w_amag_raw;
            n_s1_aneg = r_s0_a[DATA_W-1];
        end
    end

    // stage 3 logic
    logic [DISC_W-1:0] w_bbw, w_acw;
    logic [DISC_W:0]   w_diff;
    logic [DISC_W-1:0] n_s3_dmag;
    logic              n_s3_kind;

    always_comb begin
        w_bbw  = DISC_W'(r_s2_bb);
        w_acw  = {r_s2_ac, 2'b00};
        w_diff = {1'b0, w_bbw} - {1'b0, w_acw};
        priority if (r_s2_ac == '0 || r_s2_sdiff) begin
            n_s3_dmag = w_bbw + w_acw;
            n_s3_kind = KIND_REAL;
        end else if (!w_diff[DISC_W]) begin
            n_s3_dmag = w_diff[DISC_W-1:0];
            n_s3_kind = KIND_REAL;
        end else begin
            // reverse difference formed alongside, not from w_diff
            n_s3_dmag = w_acw - w_bbw;
            n_s3_kind = KIND_COMPLEX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (w_ce) begin
            r_s0_valid <= i_s_axis_tvalid;
            r_s1_valid <= r_s0_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_s0_a <= i_s_axis_tdata[DATA_W-1:0];
            r_s0_b <= i_s_axis_tdata[2*DATA_W-1:DATA_W];
            r_s0_c <= i_s_axis_tdata[3*DATA_W-1:2*DATA_W];

            r_s1_b    <= r_s0_b;
            r_s1_amag <= n_s1_amag;
            r_s1_bmag <= n_s1_bmag;
            r_s1_cmag <= n_s1_cmag;
            r_s1_aneg <= n_s1_aneg;
            r_s1_cneg <= r_s0_c[DATA_W-1];

            r_s2_bb    <= r_s1_bmag * r_s1_bmag;
            r_s2_ac    <= r_s1_amag * r_s1_cmag;
            r_s2_b     <= r_s1_b;
            r_s2_amag  <= r_s1_amag;
            r_s2_aneg  <= r_s1_aneg;
            r_s2_sdiff <= r_s1_aneg ^ r_s1_cneg;

            r_s3_dmag      <= n_s3_dmag;
            r_s3_side.kind <= n_s3_kind;
            r_s3_side.b    <= r_s2_b;
            r_s3_side.amag <= r_s2_amag;
            r_s3_side.aneg <= r_s2_aneg;
        end
    end

    logic              w_sq_valid;
    logic [ROOT_W-1:0] w_sq_root;
    t_sq_side          w_sq_side;

    qrs_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (r_s3_valid),
        .i_rad   (SQ_IN_W'(r_s3_dmag)),
        .i_side  (r_s3_side),
        .o_valid (w_sq_valid),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    // stage 4 logic: numerators, their magnitudes and quotient signs
    logic signed [NUM_W-1:0] w_s, w_b, w_n1, w_n2;
    logic [NUM_W-1:0]        w_m1, w_m2;

    always_comb begin
        w_s = NUM_W'(signed'({1'b0, w_sq_root}));
        w_b = NUM_W'(w_sq_side.b);
        if (w_sq_side.kind == KIND_COMPLEX) begin
            w_n1 = -w_b;
            w_n2 = w_s;
        end else begin
            w_n1 = w_s - w_b;
            w_n2 = -w_s - w_b;
        end
        w_m1 = w_n1[NUM_W-1] ? NUM_W'(-w_n1) : NUM_W'(w_n1);
        w_m2 = w_n2[NUM_W-1] ? NUM_W'(-w_n2) : NUM_W'(w_n2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (w_ce) begin
            r_s4_valid <= w_sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_s4_kind <= w_sq_side.kind;
            r_s4_dvd1 <= {w_m1[NMAG_W-1:0], {FRAC_BITS{1'b0}}};
            r_s4_dvd2 <= {w_m2[NMAG_W-1:0], {FRAC_BITS{1'b0}}};
            r_s4_den  <= {w_sq_side.amag, 1'b0};
            r_s4_neg1 <= w_n1[NUM_W-1] ^ w_sq_side.aneg;
            r_s4_neg2 <= w_n2[NUM_W-1] ^ w_sq_side.aneg;
        end
    end

    logic [DVD_W-1:0] w_q1, w_q2;
    logic             w_qn1, w_qn2;

    qrs_div u_div_first (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_dvd (r_s4_dvd1),
        .i_den (r_s4_den),
        .i_neg (r_s4_neg1),
        .o_quo (w_q1),
        .o_neg (w_qn1)
    );

    qrs_div u_div_second (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_dvd (r_s4_dvd2),
        .i_den (r_s4_den),
        .i_neg (r_s4_neg2),
        .o_quo (w_q2),
        .o_neg (w_qn2)
    );

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DV_STAGES; k++) begin
            if (!i_rst_n) begin
                r_dv_valid[k] <= 1'b0;
            end else if (w_ce) begin
                r_dv_valid[k] <= (k == 0) ? r_s4_valid : r_dv_valid[(k == 0) ? 0 : k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int k = 0; k < DV_STAGES; k++) begin
                r_dv_kind[k] <= (k == 0) ? r_s4_kind : r_dv_kind[(k == 0) ? 0 : k-1];
            end
        end
    end

    logic [DATA_W:0] w_sat1, w_sat2;

    assign w_sat1 = sat_q(w_q1, w_qn1);
    assign w_sat2 = sat_q(w_q2, w_qn2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ce) begin
            r_out_valid <= r_dv_valid[DV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_out_kind   <= r_dv_kind[DV_STAGES-1];
            r_out_first  <= w_sat1[DATA_W-1:0];
            r_out_second <= w_sat2[DATA_W-1:0];
            r_out_ovf    <= w_sat1[DATA_W] | w_sat2[DATA_W];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_second, r_out_first};
    assign o_m_axis_tuser  = {r_out_ovf, r_out_kind};

    logic w_s3_complex, w_first_sat, w_second_sat;

    assign w_s3_complex = (r_s3_side.kind == KIND_COMPLEX);
    assign w_first_sat  = (r_out_first == SAT_POS[DATA_W-1:0]) ||
                          (r_out_first == SAT_NEG[DATA_W-1:0]);
    assign w_second_sat = (r_out_second == SAT_POS[DATA_W-1:0]) ||
                          (r_out_second == SAT_NEG[DATA_W-1:0]);

    `QRS_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, r_s0_valid)
    `QRS_ASSERT_IMPL(a_amag_nonzero, i_clk, i_rst_n, r_s1_valid, r_s1_amag != '0)
    `QRS_ASSERT_IMPL(a_complex_nonzero, i_clk, i_rst_n, r_s3_valid && w_s3_complex, r_s3_dmag != '0)
    `QRS_ASSERT_IMPL(a_ovf_saturated, i_clk, i_rst_n, r_out_valid && r_out_ovf, w_first_sat || w_second_sat)
endmodule
`default_nettype wire

>>> hw/rtl/qrs_isqrt.sv
// pipelined floor square root, one result bit per stage
`default_nettype none
module qrs_isqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_ce,
    input  wire logic                          i_valid,
    input  wire logic [qrs_pkg::SQ_IN_W-1:0]   i_rad,
    input  wire qrs_pkg::t_sq_side             i_side,
    output logic                               o_valid,
    output logic [qrs_pkg::ROOT_W-1:0]         o_root,
    output qrs_pkg::t_sq_side                  o_side
);
    import qrs_pkg::*;

    logic                r_valid [SQ_STAGES];
    logic [SQ_REM_W-1:0] r_rem   [SQ_STAGES];
    logic [ROOT_W-1:0]   r_root  [SQ_STAGES];
    logic [SQ_IN_W-1:0]  r_x     [SQ_STAGES];
    t_sq_side            r_side  [SQ_STAGES];

    logic                w_v_in    [SQ_STAGES];
    logic [SQ_REM_W-1:0] w_rem_in  [SQ_STAGES];
    logic [ROOT_W-1:0]   w_root_in [SQ_STAGES];
    logic [SQ_IN_W-1:0]  w_x_in    [SQ_STAGES];
    t_sq_side            w_side_in [SQ_STAGES];
    logic [SQ_REM_W-1:0] w_t       [SQ_STAGES];
    logic [SQ_REM_W-1:0] w_trial   [SQ_STAGES];
    logic [SQ_REM_W-1:0] n_rem     [SQ_STAGES];
    logic [ROOT_W-1:0]   n_root    [SQ_STAGES];

    always_comb begin
        for (int k = 0; k < SQ_STAGES; k++) begin
            if (k == 0) begin
                w_v_in[k]    = i_valid;
                w_rem_in[k]  = '0;
                w_root_in[k] = '0;
                w_x_in[k]    = i_rad;
                w_side_in[k] = i_side;
            end else begin
                w_v_in[k]    = r_valid[k-1];
                w_rem_in[k]  = r_rem[k-1];
                w_root_in[k] = r_root[k-1];
                w_x_in[k]    = r_x[k-1];
                w_side_in[k] = r_side[k-1];
            end
            // bring down the next two radicand bits, try root*4+1
            w_t[k]     = {w_rem_in[k][SQ_REM_W-3:0], w_x_in[k][SQ_IN_W-1 -: 2]};
            w_trial[k] = {1'b0, w_root_in[k], 2'b01};
            if (w_t[k] >= w_trial[k]) begin
                n_rem[k]  = w_t[k] - w_trial[k];
                n_root[k] = {w_root_in[k][ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = w_t[k];
                n_root[k] = {w_root_in[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SQ_STAGES; k++) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_ce) begin
                r_valid[k] <= w_v_in[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int k = 0; k < SQ_STAGES; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_x[k]    <= {w_x_in[k][SQ_IN_W-3:0], 2'b00};
                r_side[k] <= w_side_in[k];
            end
        end
    end

    assign o_valid = r_valid[SQ_STAGES-1];
    assign o_root  = r_root[SQ_STAGES-1];
    assign o_side  = r_side[SQ_STAGES-1];
endmodule
`default_nettype wire

>>> hw/rtl/qrs_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module qrs_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_ce,
    input  wire logic [qrs_pkg::DVD_W-1:0]   i_dvd,
    input  wire logic [qrs_pkg::DEN_W-1:0]   i_den,
    input  wire logic                        i_neg,
    output logic [qrs_pkg::DVD_W-1:0]        o_quo,
    output logic                             o_neg
);
    import qrs_pkg::*;

    logic [DEN_W-1:0] r_rem [DV_STAGES];
    logic [DVD_W-1:0] r_quo [DV_STAGES];
    logic [DVD_W-1:0] r_n   [DV_STAGES];
    logic [DEN_W-1:0] r_den [DV_STAGES];
    logic             r_neg [DV_STAGES];

    logic [DEN_W-1:0] w_rem_in [DV_STAGES];
    logic [DVD_W-1:0] w_quo_in [DV_STAGES];
    logic [DVD_W-1:0] w_n_in   [DV_STAGES];
    logic [DEN_W-1:0] w_den_in [DV_STAGES];
    logic             w_neg_in [DV_STAGES];
    logic [DEN_W:0]   w_t      [DV_STAGES];
    logic [DEN_W-1:0] n_rem    [DV_STAGES];
    logic [DVD_W-1:0] n_quo    [DV_STAGES];

    always_comb begin
        for (int k = 0; k < DV_STAGES; k++) begin
            if (k == 0) begin
                w_rem_in[k] = '0;
                w_quo_in[k] = '0;
                w_n_in[k]   = i_dvd;
                w_den_in[k] = i_den;
                w_neg_in[k] = i_neg;
            end else begin
                w_rem_in[k] = r_rem[k-1];
                w_quo_in[k] = r_quo[k-1];
                w_n_in[k]   = r_n[k-1];
                w_den_in[k] = r_den[k-1];
                w_neg_in[k] = r_neg[k-1];
            end
            w_t[k] = {w_rem_in[k], w_n_in[k][DVD_W-1]};
            if (w_t[k] >= {1'b0, w_den_in[k]}) begin
                n_rem[k] = DEN_W'(w_t[k] - {1'b0, w_den_in[k]});
                n_quo[k] = {w_quo_in[k][DVD_W-2:0], 1'b1};
            end else begin
                n_rem[k] = w_t[k][DEN_W-1:0];
                n_quo[k] = {w_quo_in[k][DVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int k = 0; k < DV_STAGES; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
                r_n[k]   <= {w_n_in[k][DVD_W-2:0], 1'b0};
                r_den[k] <= w_den_in[k];
                r_neg[k] <= w_neg_in[k];
            end
        end
    end

    assign o_quo = r_quo[DV_STAGES-1];
    assign o_neg = r_neg[DV_STAGES-1];
endmodule
`default_nettype wire

>>> tb/quadratic_root_solver_checker.sv
// checker for the quadratic root solver: predicts each result from the coefficients and compares
`default_nettype none
module quadratic_root_solver_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [qrs_pkg::EPS_W-1:0]    i_cfg_wdata,
    input  wire logic                         i_s_tvalid,
    input  wire logic                         i_s_tready,
    input  wire logic [3*qrs_pkg::DATA_W-1:0] i_s_tdata,
    input  wire logic                         i_m_tvalid,
    input  wire logic                         i_m_tready,
    input  wire logic [2*qrs_pkg::DATA_W-1:0] i_m_tdata,
    input  wire logic [1:0]                   i_m_tuser,
    output int                                o_fail_count,
    output int                                o_pending
);
    typedef struct packed {
        logic        kind;
        logic [31:0] first;
        logic [31:0] second;
        logic        ovf;
    } t_roots;

    t_roots roots_q[$];
    logic [30:0] eps_reg;

    assign o_pending = roots_q.size();

    // floor square root of a value below 2^68
    function automatic logic [33:0] isqrt68(input logic [67:0] x);
        logic [33:0] r;
        logic [33:0] cand;
        r = '0;
        for (int bit_i = 33; bit_i >= 0; bit_i--) begin
            cand = r | (34'd1 << bit_i);
            if ({34'd0, cand} * {34'd0, cand} <= x) r = cand;
        end
        return r;
    endfunction

    // truncating signed divide with saturation, num given as sign and magnitude
    function automatic logic [31:0] sat_div(input logic nneg, input logic [34:0] nmag,
                                            input logic [32:0] den2, input logic den_neg,
                                            inout logic ovf);
        logic [63:0] q;
        q = ({29'd0, nmag} << qrs_pkg::FRAC_BITS) / {31'd0, den2};
        if (nneg != den_neg && q != 0) begin
            if (q > 64'h8000_0000) begin
                q = 64'h8000_0000;
                ovf = 1'b1;
            end
            return 32'(-q);
        end
        if (q > 64'h7FFF_FFFF) begin
            q = 64'h7FFF_FFFF;
            ovf = 1'b1;
        end
        return q[31:0];
    endfunction

    function automatic t_roots solve_roots(input logic [95:0] coefs, input logic [30:0] eps_v);
        logic signed [31:0] a, b, c;
        logic [31:0] amag, bmag, cmag, eps_m;
        logic aneg, ovf, cplx;
        logic [67:0] bb, ac4, dmag;
        logic [33:0] s;
        logic signed [35:0] n1, n2;
        t_roots r;
        a = coefs[31:0];
        b = coefs[63:32];
        c = coefs[95:64];
        eps_m = (eps_v == 0) ? 32'd1 : {1'b0, eps_v};
        amag = a[31] ? 32'(-a) : a;
        if (amag < eps_m) begin
            a = eps_m;
            amag = eps_m;
        end
        aneg = a[31];
        bmag = b[31] ? 32'(-b) : b;
        cmag = c[31] ? 32'(-c) : c;
        bb = {36'd0, bmag} * {36'd0, bmag};
        ac4 = ({36'd0, amag} * {36'd0, cmag}) << 2;
        cplx = 1'b0;
        if (ac4 == 0 || aneg != c[31]) dmag = bb + ac4;
        else if (bb >= ac4) dmag = bb - ac4;
        else begin
            dmag = ac4 - bb;
            cplx = 1'b1;
        end
        s = isqrt68(dmag);
        ovf = 1'b0;
        r.kind = cplx ? qrs_pkg::KIND_COMPLEX : qrs_pkg::KIND_REAL;
        if (!cplx) begin
            n1 = $signed({2'b0, s}) - 36'(b);
            n2 = -$signed({2'b0, s}) - 36'(b);
        end else begin
            n1 = -36'(b);
            n2 = $signed({2'b0, s});
        end
        r.first = sat_div(n1[35], n1[35] ? 35'(-n1) : n1[34:0], {amag, 1'b0}, aneg, ovf);
        r.second = sat_div(n2[35], n2[35] ? 35'(-n2) : n2[34:0], {amag, 1'b0}, aneg, ovf);
        r.ovf = ovf;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_roots want;
        if (!i_rst_n) begin
            eps_reg <= 31'd1;
        end else begin
            if (i_cfg_we) eps_reg <= i_cfg_wdata;
            if (i_s_tvalid && i_s_tready) roots_q.push_back(solve_roots(i_s_tdata, eps_reg));
            if (i_m_tvalid && i_m_tready) begin
                if (roots_q.size() == 0) begin
                    report_mismatch("unexpected item", i_m_tdata[31:0], 32'd0);
                end else begin
                    want = roots_q.pop_front();
                    if (i_m_tuser[0] !== want.kind)
                        report_mismatch("root_kind", i_m_tuser[0], want.kind);
                    if (i_m_tdata[31:0] !== want.first)
                        report_mismatch("first_value", i_m_tdata[31:0], want.first);
                    if (i_m_tdata[63:32] !== want.second)
                        report_mismatch("second_value", i_m_tdata[63:32], want.second);
                    if (i_m_tuser[1] !== want.ovf)
                        report_mismatch("overflow", i_m_tuser[1], want.ovf);
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> tb/quadratic_root_solver_top_tb.sv
// testbench top for the quadratic root solver: stimulus, stalls, watchdog and verdict
`default_nettype none
module quadratic_root_solver_top_tb;
    localparam int LATENCY = 89;
    localparam int WATCHDOG_LIMIT = 4000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [qrs_pkg::EPS_W-1:0] i_cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [3*qrs_pkg::DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [2*qrs_pkg::DATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;
    int fail_count;
    int pending;
    int idle_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    quadratic_root_solver_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready), .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser)
    );

    quadratic_root_solver_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_m_tuser(m_tuser), .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stall pattern: quiet stretches, random stalls, long holds
    always @(negedge i_clk) begin
        int mode;
        mode = int'(($time / 20000) % 3);
        if (mode == 0) m_tready <= 1'b1;
        else if (mode == 1) m_tready <= ($urandom_range(0, 3) != 0);
        else m_tready <= ($urandom_range(0, 9) == 0);
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [31:0] pick_coef();
        unique case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'(int'($urandom_range(0, 8)) - 4);
            3: return 32'(int'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000);
            4: return {{16{1'b0}}, 16'($urandom)} ^ {32{$urandom_range(0, 1) == 1}};
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
        s_tdata <= {c, b, a};
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic go_idle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    task automatic write_eps(input logic [30:0] v);
        go_idle();
        i_cfg_wdata <= v;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_items(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && sent < count) begin
                send_item(pick_coef(), pick_coef(), pick_coef());
                burst--;
                sent++;
            end
            if ($urandom_range(0, 2) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // directed: two real, double root, complex, tiny a, extremes
        send_item(32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000);
        send_item(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
        send_item(32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
        send_item(32'hFFFF_0000, 32'h0001_0000, 32'h0003_0000);
        send_item(32'h0000_0000, 32'h0001_0000, 32'h0001_0000);
        send_item(32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(32'h0000_0001, 32'h8000_0000, 32'h0000_0000);
        send_item(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // sender pause until everything has drained
        go_idle();
        write_eps(31'd0);
        send_item(32'h0000_0000, 32'h0001_0000, 32'h0000_0001);
        send_item(32'hFFFF_FFFF, 32'h0000_0003, 32'hFFFF_FFFF);
        write_eps(31'h7FFF_FFFF);
        send_item(32'h8000_0000, 32'h0001_0000, 32'h0001_0000);
        send_item(32'h7FFF_FFFE, 32'hFFFF_0000, 32'h0001_0000);
        random_items(100);
        write_eps(31'h0000_1000);
        send_item(32'h0000_0FFF, 32'h0000_0000, 32'h0000_1000);
        send_item(32'hFFFF_F000, 32'h0000_0000, 32'h0000_1000);
        random_items(250);
        write_eps(31'd1);
        random_items(400);
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire
